/* sv/hts_pkg.sv */
package hts_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [2:0] ent_t;
  typedef logic [2:0] len_t;

  localparam int MAX_BURST = 5;
  localparam int WIN_LEN   = 6;

  localparam byte_t CH_LT    = 8'h3c;
  localparam byte_t CH_GT    = 8'h3e;
  localparam byte_t CH_AMP   = 8'h26;
  localparam byte_t CH_SEMI  = 8'h3b;
  localparam byte_t CH_N     = 8'h6e;
  localparam byte_t CH_B     = 8'h62;
  localparam byte_t CH_S     = 8'h73;
  localparam byte_t CH_P     = 8'h70;
  localparam byte_t CH_L     = 8'h6c;
  localparam byte_t CH_T     = 8'h74;
  localparam byte_t CH_SLASH = 8'h2f;
  localparam byte_t CH_H     = 8'h68;
  localparam byte_t CH_E     = 8'h65;
  localparam byte_t CH_A     = 8'h61;
  localparam byte_t CH_D     = 8'h64;

  // "</head>", index 0 holds the first byte
  localparam byte_t [WIN_LEN:0] HEAD_MARK =
    {CH_GT, CH_D, CH_A, CH_E, CH_H, CH_SLASH, CH_LT};

  // entity match progress
  localparam ent_t ENT_NONE = 3'd0;
  localparam ent_t ENT_AMP  = 3'd1;
  localparam ent_t ENT_N    = 3'd2;
  localparam ent_t ENT_NB   = 3'd3;
  localparam ent_t ENT_NBS  = 3'd4;
  localparam ent_t ENT_NBSP = 3'd5;
  localparam ent_t ENT_L    = 3'd6;
  localparam ent_t ENT_LT   = 3'd7;

  typedef struct packed {
    logic body;
    logic tag;
    ent_t ent;
  } flags_t;

  typedef struct packed {
    byte_t [MAX_BURST-1:0] chars;
    len_t                  len;
    logic                  char_valid;
    logic                  eot;
  } burst_t;

  // number of letters held by a pending entity match
  function automatic len_t ent_len(input ent_t p);
    len_t n;
    case (p)
      ENT_N:    n = 3'd1;
      ENT_NB:   n = 3'd2;
      ENT_NBS:  n = 3'd3;
      ENT_NBSP: n = 3'd4;
      ENT_L:    n = 3'd1;
      ENT_LT:   n = 3'd2;
      default:  n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic byte_t ent_letter(input ent_t p, input logic [1:0] i);
    byte_t ch;
    if (p == ENT_L || p == ENT_LT) begin
      ch = (i == 2'd0) ? CH_L : CH_T;
    end else begin
      case (i)
        2'd0:    ch = CH_N;
        2'd1:    ch = CH_B;
        2'd2:    ch = CH_S;
        default: ch = CH_P;
      endcase
    end
    return ch;
  endfunction

endpackage

/* sv/hts_if.sv */
interface hts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       last_char;

  modport source(output valid, output in_char, output last_char, input ready);
  modport sink(input valid, input in_char, input last_char, output ready);
endinterface

interface hts_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       char_valid;
  logic       end_of_text;

  modport source(output valid, output out_char, output char_valid, output end_of_text,
                 input ready);
  modport sink(input valid, input out_char, input char_valid, input end_of_text,
               output ready);
endinterface

/* sv/hts_step.sv */
module hts_step import hts_pkg::*; #(
  parameter int OUTPUT_CAP = 4096,
  localparam int CNT_W = $clog2(OUTPUT_CAP + 1)
) (
  input  byte_t                 in_char,
  input  logic                  last_char,
  input  flags_t                flags_r,
  input  byte_t [WIN_LEN-1:0]   win_r,
  input  logic [CNT_W-1:0]      cnt_r,
  output flags_t                flags_nxt,
  output byte_t [WIN_LEN-1:0]   win_nxt,
  output logic [CNT_W-1:0]      cnt_nxt,
  output burst_t                burst
);

  localparam int CW = CNT_W + 3;

  logic                  active;
  logic [CW-1:0]         rem;
  logic                  hit;
  logic                  adv_ok;
  ent_t                  adv_next;
  logic                  ent_fail;
  logic                  emit_c;
  flags_t                flags_upd;
  byte_t [WIN_LEN-1:0]   win_upd;
  ent_t                  fp;
  len_t                  flen;
  len_t                  n_raw;
  len_t                  n_out;
  byte_t [MAX_BURST-1:0] slots;
  logic [CNT_W-1:0]      cnt_upd;

  assign rem    = CW'(OUTPUT_CAP) - CW'(cnt_r);
  assign active = CW'(cnt_r) < CW'(OUTPUT_CAP);
  assign hit    = (win_r == HEAD_MARK[WIN_LEN-1:0]) && (in_char == HEAD_MARK[WIN_LEN]);

  always_comb begin
    adv_ok   = 1'b0;
    adv_next = ENT_NONE;
    case (flags_r.ent)
      ENT_AMP: begin
        if (in_char == CH_N) begin
          adv_ok = 1'b1; adv_next = ENT_N;
        end else if (in_char == CH_L) begin
          adv_ok = 1'b1; adv_next = ENT_L;
        end
      end
      ENT_N:    if (in_char == CH_B) begin adv_ok = 1'b1; adv_next = ENT_NB; end
      ENT_NB:   if (in_char == CH_S) begin adv_ok = 1'b1; adv_next = ENT_NBS; end
      ENT_NBS:  if (in_char == CH_P) begin adv_ok = 1'b1; adv_next = ENT_NBSP; end
      ENT_NBSP: if (in_char == CH_SEMI) begin adv_ok = 1'b1; adv_next = ENT_NONE; end
      ENT_L:    if (in_char == CH_T) begin adv_ok = 1'b1; adv_next = ENT_LT; end
      ENT_LT:   if (in_char == CH_SEMI) begin adv_ok = 1'b1; adv_next = ENT_NONE; end
      default: begin
        adv_ok   = 1'b0;
        adv_next = ENT_NONE;
      end
    endcase
  end

  always_comb begin
    flags_upd = flags_r;
    win_upd   = win_r;
    ent_fail  = 1'b0;
    emit_c    = 1'b0;
    if (active) begin
      if (!flags_r.body) begin
        win_upd = {in_char, win_r[WIN_LEN-1:1]};
        if (hit) flags_upd.body = 1'b1;
      end else if (flags_r.ent != ENT_NONE && adv_ok) begin
        flags_upd.ent = adv_next;
      end else begin
        ent_fail      = (flags_r.ent != ENT_NONE);
        flags_upd.ent = ENT_NONE;
        if (in_char == CH_LT) begin
          flags_upd.tag = 1'b1;
        end else if (in_char == CH_GT) begin
          flags_upd.tag = 1'b0;
        end else if (in_char == CH_AMP) begin
          if (!flags_r.tag) flags_upd.ent = ENT_AMP;
        end else if (!flags_r.tag) begin
          emit_c = 1'b1;
        end
      end
    end
  end

  // a failed match releases its letters before the byte; at the end of the
  // document a match still pending releases its letters too
  always_comb begin
    if (!active) fp = ENT_NONE;
    else if (ent_fail) fp = flags_r.ent;
    else if (last_char) fp = flags_upd.ent;
    else fp = ENT_NONE;
  end

  assign flen  = ent_len(fp);
  assign n_raw = flen + len_t'(emit_c);
  assign n_out = (CW'(n_raw) > rem) ? rem[2:0] : n_raw;

  always_comb begin
    for (int j = 0; j < MAX_BURST; j++) begin
      if (3'(j) < flen) slots[j] = ent_letter(fp, 2'(j));
      else if (3'(j) == flen && emit_c) slots[j] = in_char;
      else slots[j] = '0;
    end
  end

  assign cnt_upd = CNT_W'(CW'(cnt_r) + CW'(n_out));

  assign flags_nxt = last_char ? '0 : flags_upd;
  assign win_nxt   = last_char ? '0 : win_upd;
  assign cnt_nxt   = last_char ? '0 : cnt_upd;

  assign burst.chars      = (n_out == 3'd0) ? '0 : slots;
  assign burst.len        = (last_char && n_out == 3'd0) ? 3'd1 : n_out;
  assign burst.char_valid = (n_out != 3'd0);
  assign burst.eot        = last_char;

endmodule

/* sv/html_tag_stripper_core.sv */
// html tag stripper: turns the bytes of an html document into its plain text.
// in_if carries one document byte per request, last_char set on the final one.
// out_if carries text bytes; end_of_text marks the final result of a document,
// and a document end that releases no byte gives one result with char_valid 0.
// everything up to and including the first "</head>" is dropped, then markup
// and the entities "&nbsp;" and "&lt;" are removed; after OUTPUT_CAP bytes of
// text the rest of the document is ignored except for its end marker.
// a result appears on out_if in the cycle after its byte is taken.
// throughput: one byte per cycle while the receiver is ready and each byte gives
// at most one result; a byte that releases the letters of a broken entity gives
// up to five results and holds the input while the register drains one a cycle.
// a new byte is taken while the last pending result is being delivered.
// if the receiver stalls, the current result holds and the input stalls while
// any result is waiting in the result register.
// reset clears the parser state and empties the result register; after the last byte
// of a document the parser is back in its reset state for the next one.
module html_tag_stripper_core import hts_pkg::*; #(
  parameter int OUTPUT_CAP = 4096
) (
  input logic       clk,
  input logic       rst_n,
  hts_in_if.sink    in_if,
  hts_out_if.source out_if
);

  localparam int CNT_W = $clog2(OUTPUT_CAP + 1);

  flags_t                flags_r, flags_nxt;
  byte_t [WIN_LEN-1:0]   win_r, win_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  burst_t                burst;
  byte_t [MAX_BURST-1:0] chars_r;
  len_t                  left_r;
  logic                  cv_r;
  logic                  eot_r;
  logic                  in_ready;
  logic                  accept;
  logic                  pop;

  hts_step #(
    .OUTPUT_CAP(OUTPUT_CAP)
  ) u_step (
    .in_char   (in_if.in_char),
    .last_char (in_if.last_char),
    .flags_r   (flags_r),
    .win_r     (win_r),
    .cnt_r     (cnt_r),
    .flags_nxt (flags_nxt),
    .win_nxt   (win_nxt),
    .cnt_nxt   (cnt_nxt),
    .burst     (burst)
  );

  assign in_ready = (left_r == 3'd0) || (left_r == 3'd1 && out_if.ready);
  assign accept   = in_if.valid && in_ready;
  assign pop      = out_if.valid && out_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
      win_r   <= '0;
      cnt_r   <= '0;
      left_r  <= 3'd0;
    end else begin
      if (accept) begin
        flags_r <= flags_nxt;
        win_r   <= win_nxt;
        cnt_r   <= cnt_nxt;
        left_r  <= burst.len;
      end else if (pop) begin
        left_r <= left_r - 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      chars_r <= burst.chars;
      cv_r    <= burst.char_valid;
      eot_r   <= burst.eot;
    end else if (pop) begin
      chars_r <= {8'h00, chars_r[MAX_BURST-1:1]};
    end
  end

  assign in_if.ready        = in_ready;
  assign out_if.valid       = (left_r != 3'd0);
  assign out_if.out_char    = chars_r[0];
  assign out_if.char_valid  = cv_r;
  assign out_if.end_of_text = eot_r && (left_r == 3'd1);

endmodule

/* sv/hts_checker.sv */
module hts_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char,
  input logic       char_valid,
  input logic       end_of_text
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(char_valid)
      && $stable(end_of_text))
    else $error("result changed while stalled");

  // a result without a byte is only the bare end marker
  a_bare_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !char_valid |-> end_of_text && out_char == 8'd0)
    else $error("bare result is not an end marker");

  // with nothing queued the block takes a request
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind html_tag_stripper_core hts_checker u_hts_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_if.ready),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .out_char    (out_if.out_char),
  .char_valid  (out_if.char_valid),
  .end_of_text (out_if.end_of_text)
);

/* dv/tb.sv */
module tb;
  import hts_pkg::*;

  localparam int TEXT_CAP   = 32;
  localparam int WATCHDOG   = 1000;
  localparam int LONG_HOLD  = 100;
  localparam int N_DIRECTED = 25;

  typedef struct packed {
    byte_t ch;
    logic  cv;
    logic  eot;
  } text_res_t;

  // typed rows carry their own expectation, the rest go through the predictor
  typedef struct packed {
    byte_t ch;
    logic  last;
    logic  typed;
    logic  has_res;
    byte_t r_ch;
    logic  r_cv;
    logic  r_eot;
  } stim_row_t;

  localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    // zero byte as a whole document: bare end marker
    '{8'h00,    1'b1, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1},
    // head mark right at the start of a document
    '{CH_LT,    1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
    '{CH_SLASH, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
    '{CH_H,     1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
    '{CH_E,     1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
    '{CH_A,     1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
    '{CH_D,     1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
    '{CH_GT,    1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
    '{8'hff,    1'b0, 1'b1, 1'b1, 8'hff, 1'b1, 1'b0},
    '{8'h00,    1'b0, 1'b1, 1'b1, 8'h00, 1'b1, 1'b0},
    '{CH_AMP,   1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
    // broken entity releases its letters, then the byte itself
    '{CH_N,     1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{CH_B,     1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{8'h78,    1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{CH_AMP,   1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{CH_L,     1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{CH_T,     1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{CH_SEMI,  1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    // ampersand inside markup
    '{CH_LT,    1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{CH_AMP,   1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{CH_GT,    1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    // entity still open at the last byte
    '{CH_AMP,   1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{CH_N,     1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{CH_B,     1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{CH_S,     1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0}
  };

  logic clk = 1'b0;
  logic rst_n;

  hts_in_if  in_if();
  hts_out_if out_if();

  html_tag_stripper_core #(.OUTPUT_CAP(TEXT_CAP)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // stripper state as the predictor sees it
  logic  body_seen;
  logic  in_markup;
  byte_t head_hist [WIN_LEN];
  ent_t  ent_state;
  int    text_count;

  text_res_t burst[$];
  text_res_t text_q[$];
  byte_t     doc[$];

  int errors      = 0;
  int idle_cycles = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_asks   = 0;

  function automatic void clear_doc_state();
    body_seen  = 1'b0;
    in_markup  = 1'b0;
    ent_state  = ENT_NONE;
    text_count = 0;
    for (int i = 0; i < WIN_LEN; i++) head_hist[i] = 8'h00;
  endfunction

  function automatic void put_text(byte_t c);
    if (text_count >= TEXT_CAP || burst.size() >= MAX_BURST) return;
    burst.push_back('{c, 1'b1, 1'b0});
    text_count++;
  endfunction

  // letters of a pending entity go out without the ampersand
  function automatic void release_entity();
    case (ent_state)
      ENT_N, ENT_NB, ENT_NBS, ENT_NBSP: begin
        put_text(CH_N);
        if (ent_state != ENT_N) put_text(CH_B);
        if (ent_state == ENT_NBS || ent_state == ENT_NBSP) put_text(CH_S);
        if (ent_state == ENT_NBSP) put_text(CH_P);
      end
      ENT_L, ENT_LT: begin
        put_text(CH_L);
        if (ent_state == ENT_LT) put_text(CH_T);
      end
      default: ;
    endcase
    ent_state = ENT_NONE;
  endfunction

  function automatic bit entity_takes(byte_t c);
    ent_t nxt;
    bit   ok;
    nxt = ENT_NONE;
    ok  = 1'b0;
    case (ent_state)
      ENT_AMP: begin
        if (c == CH_N) begin
          nxt = ENT_N;
          ok  = 1'b1;
        end else if (c == CH_L) begin
          nxt = ENT_L;
          ok  = 1'b1;
        end
      end
      ENT_N:    if (c == CH_B) begin nxt = ENT_NBS - 3'd1; ok = 1'b1; end
      ENT_NB:   if (c == CH_S) begin nxt = ENT_NBS; ok = 1'b1; end
      ENT_NBS:  if (c == CH_P) begin nxt = ENT_NBSP; ok = 1'b1; end
      ENT_NBSP: if (c == CH_SEMI) ok = 1'b1;
      ENT_L:    if (c == CH_T) begin nxt = ENT_LT; ok = 1'b1; end
      ENT_LT:   if (c == CH_SEMI) ok = 1'b1;
      default: ;
    endcase
    if (ok) begin
      ent_state = nxt;
      return 1'b1;
    end
    release_entity();
    return 1'b0;
  endfunction

  function automatic void strip_byte(byte_t c, logic last);
    bit        hit;
    bit        taken;
    text_res_t r;
    burst.delete();
    if (text_count < TEXT_CAP) begin
      if (body_seen) begin
        taken = 1'b0;
        if (ent_state != ENT_NONE) taken = entity_takes(c);
        if (!taken) begin
          if (c == CH_LT) begin
            in_markup = 1'b1;
          end else if (c == CH_GT) begin
            in_markup = 1'b0;
          end else if (c == CH_AMP) begin
            if (!in_markup) ent_state = ENT_AMP;
          end else if (!in_markup) begin
            put_text(c);
          end
        end
      end else begin
        hit = (c == HEAD_MARK[WIN_LEN]);
        for (int i = 0; i < WIN_LEN; i++)
          if (head_hist[i] != HEAD_MARK[i]) hit = 1'b0;
        for (int i = 0; i < WIN_LEN - 1; i++) head_hist[i] = head_hist[i+1];
        head_hist[WIN_LEN-1] = c;
        if (hit) body_seen = 1'b1;
      end
      if (last && body_seen && ent_state != ENT_NONE) release_entity();
    end
    if (last) begin
      if (burst.size() == 0) begin
        burst.push_back('{8'h00, 1'b0, 1'b1});
      end else begin
        r = burst.pop_back();
        r.eot = 1'b1;
        burst.push_back(r);
      end
      clear_doc_state();
    end
  endfunction

  function automatic void add_str(string s);
    for (int i = 0; i < s.len(); i++) doc.push_back(byte_t'(s[i]));
  endfunction

  function automatic byte_t head_noise();
    byte_t c;
    case ($urandom_range(7))
      0: c = CH_LT;
      1: c = CH_SLASH;
      2: c = CH_H;
      3: c = CH_E;
      4: c = CH_A;
      5: c = CH_D;
      6: c = CH_GT;
      default: c = byte_t'($urandom_range(255));
    endcase
    return c;
  endfunction

  function automatic void add_body_token();
    int    pick;
    int    k;
    string ent;
    pick = $urandom_range(99);
    if (pick < 40) begin
      doc.push_back(byte_t'($urandom_range(8'h7e, 8'h20)));
    end else if (pick < 50) begin
      doc.push_back(byte_t'($urandom_range(255)));
    end else if (pick < 62) begin
      doc.push_back(CH_LT);
      repeat ($urandom_range(4)) doc.push_back(byte_t'($urandom_range(8'h7a, 8'h61)));
      if ($urandom_range(3) == 0) doc.push_back(CH_AMP);
      doc.push_back(CH_GT);
    end else if (pick < 72) begin
      add_str("&nbsp;");
    end else if (pick < 80) begin
      add_str("&lt;");
    end else if (pick < 95) begin
      // broken entity: a prefix, then whatever comes next
      if ($urandom_range(1) == 1) ent = "&nbsp;";
      else ent = "&lt;";
      k = $urandom_range(ent.len() - 1, 1);
      add_str(ent.substr(0, k - 1));
      if (pick < 88) doc.push_back(byte_t'($urandom_range(8'h7e, 8'h20)));
      else doc.push_back(CH_AMP);
    end else begin
      doc.push_back(($urandom_range(1) == 1) ? CH_LT : CH_GT);
    end
  endfunction

  function automatic void build_document();
    int kind;
    int n;
    kind = $urandom_range(99);
    doc.delete();
    repeat ($urandom_range(6)) doc.push_back(head_noise());
    if (kind < 10) begin
      // never leaves the head
      repeat ($urandom_range(20, 1)) doc.push_back(byte_t'($urandom_range(255)));
    end else begin
      if (kind < 25) add_str("</hea");
      add_str("</head>");
      n = (kind < 40) ? $urandom_range(45, 20) : $urandom_range(15);
      repeat (n) add_body_token();
    end
  endfunction

  task automatic send_request(input byte_t c, input logic last, input bit typed,
                              input bit has_res, input text_res_t res);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.in_char   <= c;
    in_if.last_char <= last;
    do @(posedge clk); while (!in_if.ready);
    strip_byte(c, last);
    if (!typed) begin
      foreach (burst[i]) text_q.push_back(burst[i]);
    end else if (has_res) begin
      text_q.push_back(res);
    end
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (text_q.size() != 0) @(posedge clk);
  endtask

  task automatic run_phase(input int tx_pct, input int rx_pct, input int n_items);
    int sent;
    sent        = 0;
    tx_idle_pct = tx_pct;
    rx_idle_pct <= rx_pct;
    while (sent < n_items) begin
      build_document();
      foreach (doc[i]) send_request(doc[i], i == doc.size() - 1, 1'b0, 1'b0, '0);
      sent += doc.size();
    end
    wait_drained();
  endtask

  // receiver side, with one long hold-off on request
  initial begin : rx_side
    int hold_left;
    int holds_seen;
    hold_left    = 0;
    holds_seen   = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_asks != holds_seen) begin
        holds_seen = hold_asks;
        hold_left  = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : text_check
    text_res_t e;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (text_q.size() == 0) begin
        $error("unexpected result: out_char %02h char_valid %0b end_of_text %0b",
               out_if.out_char, out_if.char_valid, out_if.end_of_text);
        errors++;
      end else begin
        e = text_q.pop_front();
        if (out_if.out_char !== e.ch) begin
          $error("out_char: expected %02h, got %02h", e.ch, out_if.out_char);
          errors++;
        end
        if (out_if.char_valid !== e.cv) begin
          $error("char_valid: expected %0b, got %0b", e.cv, out_if.char_valid);
          errors++;
        end
        if (out_if.end_of_text !== e.eot) begin
          $error("end_of_text: expected %0b, got %0b", e.eot, out_if.end_of_text);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : main
    stim_row_t row;
    rst_n           = 1'b0;
    in_if.valid     = 1'b0;
    in_if.in_char   = 8'h00;
    in_if.last_char = 1'b0;
    clear_doc_state();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    tx_idle_pct = 35;
    rx_idle_pct <= 75;
    for (int i = 0; i < N_DIRECTED; i++) begin
      row = DIRECTED_ROWS[i];
      send_request(row.ch, row.last, row.typed, row.has_res,
                   '{row.r_ch, row.r_cv, row.r_eot});
    end

    run_phase(35, 75, 90);
    run_phase(75, 35, 90);
    // block fills up behind a stalled receiver
    hold_asks <= hold_asks + 1;
    run_phase(0, 0, 90);

    repeat (20) @(posedge clk);
    if (errors == 0 && text_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* html_tag_stripper_core.f */
sv/hts_pkg.sv
sv/hts_if.sv
sv/hts_step.sv
sv/html_tag_stripper_core.sv
sv/hts_checker.sv
dv/tb.sv
